// ----- rtl/wem_pkg.sv -----
package wem_pkg;

    // Default sizing, handed to the top level parameters
    localparam int MAX_COLS_DEF   = 128;
    localparam int MAX_ROWS_DEF   = 128;
    localparam int MAX_EXTENT_DEF = 7;
    localparam int PIXEL_BITS_DEF = 16;

    // Register field widths
    localparam int EXT_REG_W  = 3;
    localparam int GAIN_W     = 16;
    localparam int DIM_REG_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register reset values
    localparam logic [EXT_REG_W-1:0] EXT_UP_RST    = 3'd1;
    localparam logic [EXT_REG_W-1:0] EXT_DOWN_RST  = 3'd2;
    localparam logic [EXT_REG_W-1:0] EXT_LEFT_RST  = 3'd1;
    localparam logic [EXT_REG_W-1:0] EXT_RIGHT_RST = 3'd2;
    localparam logic [GAIN_W-1:0]    HIT_GAIN_RST  = 16'sd256;
    localparam logic [GAIN_W-1:0]    MISS_GAIN_RST = 16'sd0;
    localparam logic [DIM_REG_W-1:0] COLS_RST      = 8'd128;
    localparam logic [DIM_REG_W-1:0] ROWS_RST      = 8'd128;

    // Item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EMIT = 1'b1;

    // Configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXT_UP    = 3'd0,
        REG_EXT_DOWN  = 3'd1,
        REG_EXT_LEFT  = 3'd2,
        REG_EXT_RIGHT = 3'd3,
        REG_HIT_GAIN  = 3'd4,
        REG_MISS_GAIN = 3'd5,
        REG_COLS      = 3'd6,
        REG_ROWS      = 3'd7
    } cfg_index_t;

    // Emit sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_BOUNDS,
        ST_BASE,
        ST_SCAN,
        ST_DRAIN,
        ST_MUL,
        ST_DONE
    } wem_state_t;

endpackage

// ----- rtl/wem_if.sv -----
// Input item channel
interface wem_item_if
    import wem_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic signed [PIXEL_BITS-1:0] pixel_value;

    modport source (output valid, output kind, output pixel_value, input ready);
    modport sink   (input valid, input kind, input pixel_value, output ready);
endinterface

// Result channel
interface wem_result_if
    import wem_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
);
    logic                                valid;
    logic                                ready;
    logic signed [PIXEL_BITS+GAIN_W-1:0] masked_value;
    logic                                is_extremum;
    logic                                plane_end;

    modport source (output valid, output masked_value, output is_extremum,
                    output plane_end, input ready);
    modport sink   (input valid, input masked_value, input is_extremum,
                    input plane_end, output ready);
endinterface

// Configuration write channel
interface wem_cfg_if
    import wem_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/window_extremum_mask_core.sv -----
// Window extremum mask over one feature plane.
// Channels: item (sink) carries kind and pixel_value, result (source) carries
// masked_value, is_extremum and plane_end, cfg (sink) writes the eight
// registers by index and is always ready.
// Load items (kind 0) write the next pixel in raster order and produce no
// result. Once the plane is full, emit items (kind 1) each produce the result
// for the next pixel. An emit before the plane is full is dropped. After the
// plane_end result the plane must be loaded again.
// An emit runs in order: accept, a bit-serial row/column split of the pixel
// index (one quotient bit a cycle, the full index width whatever plane size
// is in use), window bounds and the center read, one plane memory read per
// window entry (up to 14 x 14), then drain, multiply and output. The single
// read port of the plane memory sets the scan rate.
// item.ready is low while an emit runs.
// Results sit in an output register; while the receiver stalls, loads are
// still taken, and a following emit waits in its last cycle until the
// register frees up. Reset clears positions, configuration registers and
// the output valid; the plane memory is not cleared.
module window_extremum_mask_core
    import wem_pkg::*;
#(
    parameter int MAX_COLS   = MAX_COLS_DEF,
    parameter int MAX_ROWS   = MAX_ROWS_DEF,
    parameter int MAX_EXTENT = MAX_EXTENT_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    wem_item_if.sink      item,
    wem_result_if.source  result,
    wem_cfg_if.sink       cfg
);

    localparam int DEPTH   = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int POS_W   = $clog2(DEPTH + 1);
    localparam int CNT_W   = $clog2(POS_W + 1);
    localparam int COL_W   = $clog2(MAX_COLS + 1);
    localparam int ROW_W   = $clog2(MAX_ROWS + 1);
    localparam int EXT_W   = $clog2(MAX_EXTENT + 1);
    localparam int RS_W    = ((ROW_W > EXT_W) ? ROW_W : EXT_W) + 1;
    localparam int CS_W    = ((COL_W > EXT_W) ? COL_W : EXT_W) + 1;
    localparam int VALUE_W = PIXEL_BITS + GAIN_W;

    // Configuration registers
    logic [EXT_REG_W-1:0]     ext_up_reg, ext_down_reg, ext_left_reg, ext_right_reg;
    logic signed [GAIN_W-1:0] hit_gain_reg, miss_gain_reg;
    logic [DIM_REG_W-1:0]     cols_cfg_reg, rows_cfg_reg;

    // Sequencer and datapath registers
    wem_state_t               state_reg, state_next;
    logic [POS_W-1:0]         load_pos_reg, load_pos_next;
    logic [POS_W-1:0]         emit_pos_reg, emit_pos_next;
    logic [POS_W-1:0]         idx_reg, idx_next;
    logic [POS_W-1:0]         dvd_reg, dvd_next;
    logic [POS_W-1:0]         quo_reg, quo_next;
    logic [COL_W-1:0]         rem_reg, rem_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [ROW_W-1:0]         r0_reg, r0_next;
    logic [ROW_W-1:0]         r_last_reg, r_last_next;
    logic [COL_W-1:0]         c0_reg, c0_next;
    logic [COL_W-1:0]         c_last_reg, c_last_next;
    logic                     empty_reg, empty_next;
    logic [ROW_W-1:0]         ri_reg, ri_next;
    logic [COL_W-1:0]         ci_reg, ci_next;
    logic [POS_W-1:0]         base_reg, base_next;
    logic signed [PIXEL_BITS-1:0] val_reg, val_next;
    logic                     max_reg, max_next;
    logic                     min_reg, min_next;
    logic                     pend_reg, pend_next;
    logic                     early_reg, early_next;
    logic                     ext_reg, ext_next;
    logic signed [VALUE_W-1:0] prod_reg, prod_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] out_value_reg, out_value_next;
    logic                     out_ext_reg, out_ext_next;
    logic                     out_end_reg, out_end_next;

    // Effective (clamped) settings
    logic [COL_W-1:0]         cols_eff;
    logic [ROW_W-1:0]         rows_eff;
    logic [EXT_W-1:0]         up_eff, down_eff, left_eff, right_eff;
    logic [POS_W-1:0]         size;
    logic                     plane_full;
    logic                     item_xfer;
    logic                     out_free;
    logic                     div_done;
    logic                     scan_last;
    logic                     is_last;

    // Division step, window bounds
    logic [COL_W:0]           div_trial;
    logic                     div_bit;
    logic [ROW_W-1:0]         row_c;
    logic [RS_W-1:0]          r_w, up_w, down_w, r_sum;
    logic [CS_W-1:0]          c_w, left_w, right_w, c_sum;
    logic [ROW_W-1:0]         r0_calc, r1_calc;
    logic [COL_W-1:0]         c0_calc, c1_calc;

    // Plane memory port
    logic                     wr_en, rd_en;
    logic [ADDR_W-1:0]        wr_addr, rd_addr;
    logic [PIXEL_BITS-1:0]    rd_data;
    logic signed [PIXEL_BITS-1:0] nb;

    wem_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (DEPTH)
    ) u_plane (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (item.pixel_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Clamp settings to the supported range
    always_comb
    begin
        if (cols_cfg_reg == '0)
            cols_eff = COL_W'(1);
        else if (32'(cols_cfg_reg) > MAX_COLS)
            cols_eff = COL_W'(MAX_COLS);
        else
            cols_eff = COL_W'(cols_cfg_reg);

        if (rows_cfg_reg == '0)
            rows_eff = ROW_W'(1);
        else if (32'(rows_cfg_reg) > MAX_ROWS)
            rows_eff = ROW_W'(MAX_ROWS);
        else
            rows_eff = ROW_W'(rows_cfg_reg);

        up_eff    = (32'(ext_up_reg) > MAX_EXTENT)    ? EXT_W'(MAX_EXTENT) : EXT_W'(ext_up_reg);
        down_eff  = (32'(ext_down_reg) > MAX_EXTENT)  ? EXT_W'(MAX_EXTENT) : EXT_W'(ext_down_reg);
        left_eff  = (32'(ext_left_reg) > MAX_EXTENT)  ? EXT_W'(MAX_EXTENT) : EXT_W'(ext_left_reg);
        right_eff = (32'(ext_right_reg) > MAX_EXTENT) ? EXT_W'(MAX_EXTENT) : EXT_W'(ext_right_reg);
    end

    assign size       = POS_W'(POS_W'(cols_eff) * POS_W'(rows_eff));
    assign plane_full = !(load_pos_reg < size);
    assign item_xfer  = item.valid && item.ready;
    assign out_free   = !out_valid_reg || result.ready;
    assign div_done   = (cnt_reg == CNT_W'(POS_W - 1));
    assign scan_last  = (ci_reg == c_last_reg) && (ri_reg == r_last_reg);
    assign is_last    = (idx_reg == POS_W'(size - POS_W'(1)));
    assign nb         = $signed(rd_data);

    // Restoring division step: one quotient bit per cycle
    assign div_trial = {rem_reg, dvd_reg[POS_W-1]};
    assign div_bit   = (div_trial >= {1'b0, cols_eff});

    // Window bounds, clipped to the plane
    always_comb
    begin
        row_c   = quo_reg[ROW_W-1:0];
        r_w     = RS_W'(row_c);
        up_w    = RS_W'(up_eff);
        down_w  = RS_W'(down_eff);
        r_sum   = r_w + down_w;
        r0_calc = (r_w > up_w) ? ROW_W'(r_w - up_w) : '0;
        r1_calc = (r_sum < RS_W'(rows_eff)) ? ROW_W'(r_sum) : rows_eff;

        c_w     = CS_W'(rem_reg);
        left_w  = CS_W'(left_eff);
        right_w = CS_W'(right_eff);
        c_sum   = c_w + right_w;
        c0_calc = (c_w > left_w) ? COL_W'(c_w - left_w) : '0;
        c1_calc = (c_sum < CS_W'(cols_eff)) ? COL_W'(c_sum) : cols_eff;
    end

    // Configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_up_reg    <= EXT_UP_RST;
            ext_down_reg  <= EXT_DOWN_RST;
            ext_left_reg  <= EXT_LEFT_RST;
            ext_right_reg <= EXT_RIGHT_RST;
            hit_gain_reg  <= HIT_GAIN_RST;
            miss_gain_reg <= MISS_GAIN_RST;
            cols_cfg_reg  <= COLS_RST;
            rows_cfg_reg  <= ROWS_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_index_t'(cfg.index))
                REG_EXT_UP:    ext_up_reg    <= cfg.data[EXT_REG_W-1:0];
                REG_EXT_DOWN:  ext_down_reg  <= cfg.data[EXT_REG_W-1:0];
                REG_EXT_LEFT:  ext_left_reg  <= cfg.data[EXT_REG_W-1:0];
                REG_EXT_RIGHT: ext_right_reg <= cfg.data[EXT_REG_W-1:0];
                REG_HIT_GAIN:  hit_gain_reg  <= $signed(cfg.data[GAIN_W-1:0]);
                REG_MISS_GAIN: miss_gain_reg <= $signed(cfg.data[GAIN_W-1:0]);
                REG_COLS:      cols_cfg_reg  <= cfg.data[DIM_REG_W-1:0];
                REG_ROWS:      rows_cfg_reg  <= cfg.data[DIM_REG_W-1:0];
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_xfer && (item.kind == KIND_EMIT) && plane_full)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_BOUNDS;
            end
            ST_BOUNDS:
                state_next = ST_BASE;
            ST_BASE:
                state_next = empty_reg ? ST_MUL : ST_SCAN;
            ST_SCAN:
            begin
                if (scan_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
                state_next = ST_MUL;
            ST_MUL:
                state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    assign item.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        load_pos_next  = load_pos_reg;
        emit_pos_next  = emit_pos_reg;
        idx_next       = idx_reg;
        dvd_next       = dvd_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        r0_next        = r0_reg;
        r_last_next    = r_last_reg;
        c0_next        = c0_reg;
        c_last_next    = c_last_reg;
        empty_next     = empty_reg;
        ri_next        = ri_reg;
        ci_next        = ci_reg;
        base_next      = base_reg;
        val_next       = val_reg;
        max_next       = max_reg;
        min_next       = min_reg;
        pend_next      = 1'b0;
        early_next     = early_reg;
        ext_next       = ext_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_value_next = out_value_reg;
        out_ext_next   = out_ext_reg;
        out_end_next   = out_end_reg;
        wr_en          = 1'b0;
        wr_addr        = load_pos_reg[ADDR_W-1:0];
        rd_en          = 1'b0;
        rd_addr        = idx_reg[ADDR_W-1:0];

        // Compare the entry read in the previous cycle
        if (pend_reg)
        begin
            if (nb > val_reg)
                max_next = 1'b0;
            if (nb < val_reg)
                min_next = 1'b0;
            if ((nb == val_reg) && early_reg)
            begin
                max_next = 1'b0;
                min_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_xfer && (item.kind == KIND_LOAD) && !plane_full)
                begin
                    wr_en         = 1'b1;
                    load_pos_next = load_pos_reg + POS_W'(1);
                end
                else if (item_xfer && (item.kind == KIND_EMIT) && plane_full)
                begin
                    idx_next = (emit_pos_reg >= size) ? '0 : emit_pos_reg;
                    dvd_next = (emit_pos_reg >= size) ? '0 : emit_pos_reg;
                    quo_next = '0;
                    rem_next = '0;
                    cnt_next = '0;
                end
            end
            ST_DIV:
            begin
                quo_next = POS_W'({quo_reg, div_bit});
                rem_next = div_bit ? COL_W'(div_trial - {1'b0, cols_eff})
                                   : COL_W'(div_trial);
                dvd_next = POS_W'({dvd_reg, 1'b0});
                cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_BOUNDS:
            begin
                // Center pixel read; window limits, empty once clipped
                rd_en       = 1'b1;
                r0_next     = r0_calc;
                r_last_next = ROW_W'(r1_calc - ROW_W'(1));
                c0_next     = c0_calc;
                c_last_next = COL_W'(c1_calc - COL_W'(1));
                empty_next  = (r1_calc <= r0_calc) || (c1_calc <= c0_calc);
            end
            ST_BASE:
            begin
                val_next  = $signed(rd_data);
                base_next = POS_W'(POS_W'(r0_reg) * POS_W'(cols_eff));
                ri_next   = r0_reg;
                ci_next   = c0_reg;
                max_next  = 1'b1;
                min_next  = 1'b1;
            end
            ST_SCAN:
            begin
                // One window entry per cycle
                rd_en      = 1'b1;
                rd_addr    = ADDR_W'(base_reg + POS_W'(ci_reg));
                pend_next  = 1'b1;
                early_next = (ri_reg < quo_reg[ROW_W-1:0]) || (ci_reg < rem_reg);
                if (ci_reg == c_last_reg)
                begin
                    ci_next   = c0_reg;
                    ri_next   = ri_reg + ROW_W'(1);
                    base_next = base_reg + POS_W'(cols_eff);
                end
                else
                begin
                    ci_next = ci_reg + COL_W'(1);
                end
            end
            ST_DRAIN:
            begin
            end
            ST_MUL:
            begin
                ext_next  = max_reg || min_reg;
                prod_next = val_reg * ((max_reg || min_reg) ? hit_gain_reg : miss_gain_reg);
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = prod_reg;
                    out_ext_next   = ext_reg;
                    out_end_next   = is_last;
                    if (is_last)
                    begin
                        emit_pos_next = '0;
                        load_pos_next = '0;
                    end
                    else
                    begin
                        emit_pos_next = idx_reg + POS_W'(1);
                    end
                end
            end
        endcase
    end

    assign result.valid        = out_valid_reg;
    assign result.masked_value = out_value_reg;
    assign result.is_extremum  = out_ext_reg;
    assign result.plane_end    = out_end_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            load_pos_reg  <= '0;
            emit_pos_reg  <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            load_pos_reg  <= load_pos_next;
            emit_pos_reg  <= emit_pos_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        dvd_reg       <= dvd_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        cnt_reg       <= cnt_next;
        r0_reg        <= r0_next;
        r_last_reg    <= r_last_next;
        c0_reg        <= c0_next;
        c_last_reg    <= c_last_next;
        empty_reg     <= empty_next;
        ri_reg        <= ri_next;
        ci_reg        <= ci_next;
        base_reg      <= base_next;
        val_reg       <= val_next;
        max_reg       <= max_next;
        min_reg       <= min_next;
        early_reg     <= early_next;
        ext_reg       <= ext_next;
        prod_reg      <= prod_next;
        out_value_reg <= out_value_next;
        out_ext_reg   <= out_ext_next;
        out_end_reg   <= out_end_next;
    end

endmodule

// ----- rtl/wem_ram.sv -----
module wem_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
